### rtl/hash_table_chaining_with_replacement_macros.svh
// Assertion macros for the hash table block.
// Used by the top level; needs clk_i and rst_ni in scope.
`ifndef HASH_TABLE_CHAINING_WITH_REPLACEMENT_MACROS_SVH
`define HASH_TABLE_CHAINING_WITH_REPLACEMENT_MACROS_SVH

// Same-cycle implication.
`define HTC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/htc_pkg.sv
// Shared types and constants for the hash table block.
// No dependencies.
`default_nettype none
package htc_pkg;
  localparam int unsigned TABLE_SLOTS_DEF = 16;
  localparam int unsigned KEY_W  = 34;
  localparam int unsigned PAY_W  = 64;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned SLOT_W = 4;

  typedef enum logic [STAT_W-1:0] {
    STAT_INSERTED = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_FOUND    = 2'd2,
    STAT_MISSING  = 2'd3
  } status_e;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_SEARCH = 1'b1
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MOD, ST_HOME_RD, ST_HOME_CHK, ST_FREE, ST_WALK_RD, ST_WALK,
    ST_WR_P, ST_WR_T, ST_WR_F, ST_WR_H, ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    WK_SEARCH, WK_TAIL, WK_PRED
  } walk_e;
endpackage
`default_nettype wire

### rtl/htc_if.sv
// Request and response channel interfaces.
// Depends on htc_pkg.
`default_nettype none
interface htc_in_if;
  import htc_pkg::*;
  logic             valid;
  logic             ready;
  logic             kind;
  logic [KEY_W-1:0] key;
  logic [PAY_W-1:0] payload;
  modport source (output valid, kind, key, payload, input ready);
  modport sink   (input valid, kind, key, payload, output ready);
endinterface

interface htc_out_if;
  import htc_pkg::*;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [SLOT_W-1:0] slot;
  logic [PAY_W-1:0]  found_payload;
  modport source (output valid, status, slot, found_payload, input ready);
  modport sink   (input valid, status, slot, found_payload, output ready);
endinterface
`default_nettype wire

### rtl/hash_table_chaining_with_replacement.sv
// Coalesced chaining hash table with replacement, one request at a time.
// Each request first reduces its key mod TABLE_SLOTS by reciprocal multiply; a search
// then reads the home slot and walks the chain one slot a cycle until a hit or its end.
// An insert may add a home read, a free-slot probe, a mod of the resident key, up to two
// chain walks and the link and record writes. No new request is taken until the result is.
// Reset: asynchronous; clears occupancy, so every link reads as none.
`default_nettype none
`include "hash_table_chaining_with_replacement_macros.svh"
module hash_table_chaining_with_replacement #(
  parameter int unsigned TABLE_SLOTS = htc_pkg::TABLE_SLOTS_DEF
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  htc_in_if.sink    in_i,
  htc_out_if.source out_o
);
  import htc_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_SLOTS);
  localparam int unsigned LW = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned CW = 2;
  localparam logic [LW-1:0] NONE = LW'(TABLE_SLOTS);
  localparam logic [IW-1:0] LAST = IW'(TABLE_SLOTS - 1);
  localparam int unsigned QS     = KEY_W + IW;
  localparam int unsigned MLO_W  = 18;
  localparam int unsigned PROD_W = KEY_W + MLO_W;
  localparam int unsigned ACC_W  = 2 * KEY_W + 1;
  localparam longint unsigned M_ALL =
    ((64'd1 << QS) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS);
  localparam logic [MLO_W-1:0] M_LO = MLO_W'(M_ALL);
  localparam logic [MLO_W-1:0] M_HI = MLO_W'(M_ALL >> MLO_W);
  localparam logic [IW-1:0]    N_LO = IW'(TABLE_SLOTS);
  localparam logic [CW-1:0]    MOD_LAST = 2'd2;

  logic [KEY_W-1:0] key_mem  [TABLE_SLOTS];
  logic [PAY_W-1:0] pay_mem  [TABLE_SLOTS];
  logic [LW-1:0]    link_mem [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] occ_q, occ_d;

  state_e state_q, state_d;
  walk_e  walk_q, walk_d;
  logic kind_q, kind_d, mres_q, mres_d, repl_q, repl_d;
  logic [KEY_W-1:0] key_q, key_d, rk_q, rk_d, src_q, src_d;
  logic [PAY_W-1:0] pay_q, pay_d, rpay_q, rpay_d, res_pay_q, res_pay_d;
  logic [LW-1:0] rlink_q, rlink_d, n_q, n_d;
  logic [IW-1:0] h_q, h_d, rh_q, rh_d, cur_q, cur_d, f_q, f_d, fs_q, fs_d;
  logic [IW-1:0] fn_q, fn_d, t_q, t_d, p_q, p_d, res_slot_q, res_slot_d;
  logic [CW-1:0] mcnt_q, mcnt_d;
  logic [STAT_W-1:0] res_stat_q, res_stat_d;
  logic [ACC_W-1:0] acc_q, acc_d;

  logic [KEY_W-1:0] rd_key_q;
  logic [PAY_W-1:0] rd_pay_q;
  logic [LW-1:0]    rd_link_q;
  logic             rd_occ_q;
  logic [IW-1:0]    rd_addr, wr_addr;
  logic             we_rec, we_link;
  logic [KEY_W-1:0] wr_key;
  logic [PAY_W-1:0] wr_pay;
  logic [LW-1:0]    wr_link;

  logic [MLO_W-1:0]  m_sel;
  logic [PROD_W-1:0] prod;
  logic [IW-1:0]     mod_out;
  logic [LW-1:0] lk;
  logic          lk_end, key_hit, n_end;

  assign m_sel   = mcnt_q[0] ? M_HI : M_LO;
  assign prod    = PROD_W'(src_q) * PROD_W'(m_sel);
  assign mod_out = IW'(src_q) - IW'(IW'(acc_q >> QS) * N_LO);
  assign lk      = rd_occ_q ? rd_link_q : NONE;
  assign lk_end  = lk >= NONE;
  assign key_hit = rd_occ_q && (rd_key_q == key_q);
  assign n_end   = n_q == NONE;
  assign rd_addr = (state_q == ST_WALK) ? IW'(lk) : cur_q;

  always_ff @(posedge clk_i) begin
    if (we_rec) begin
      key_mem[wr_addr] <= wr_key;
      pay_mem[wr_addr] <= wr_pay;
    end
    if (we_link) link_mem[wr_addr] <= wr_link;
    rd_key_q  <= key_mem[rd_addr];
    rd_pay_q  <= pay_mem[rd_addr];
    rd_link_q <= link_mem[rd_addr];
    rd_occ_q  <= occ_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      occ_q   <= '0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    walk_q <= walk_d; kind_q <= kind_d; mres_q <= mres_d; repl_q <= repl_d;
    key_q <= key_d; rk_q <= rk_d; src_q <= src_d;
    pay_q <= pay_d; rpay_q <= rpay_d; res_pay_q <= res_pay_d;
    rlink_q <= rlink_d; n_q <= n_d;
    h_q <= h_d; rh_q <= rh_d; cur_q <= cur_d; f_q <= f_d; fs_q <= fs_d;
    fn_q <= fn_d; t_q <= t_d; p_q <= p_d; res_slot_q <= res_slot_d;
    mcnt_q <= mcnt_d; res_stat_q <= res_stat_d; acc_q <= acc_d;
  end

  always_comb begin
    state_d = state_q; walk_d = walk_q; kind_d = kind_q; mres_d = mres_q;
    repl_d = repl_q; key_d = key_q; rk_d = rk_q; src_d = src_q;
    pay_d = pay_q; rpay_d = rpay_q; res_pay_d = res_pay_q; rlink_d = rlink_q;
    n_d = n_q; h_d = h_q; rh_d = rh_q; cur_d = cur_q; f_d = f_q; fs_d = fs_q;
    fn_d = fn_q; t_d = t_q; p_d = p_q; acc_d = acc_q; res_slot_d = res_slot_q;
    mcnt_d = mcnt_q; res_stat_d = res_stat_q; occ_d = occ_q;
    we_rec = 1'b0; we_link = 1'b0; wr_addr = cur_q;
    wr_key = key_q; wr_pay = pay_q; wr_link = NONE;
    in_i.ready = 1'b0;
    out_o.valid = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          kind_d = in_i.kind; key_d = in_i.key; pay_d = in_i.payload;
          src_d = in_i.key; mcnt_d = '0; mres_d = 1'b0;
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        mcnt_d = mcnt_q + 1'b1;
        if (mcnt_q == 2'd0) begin
          acc_d = ACC_W'(prod);
        end else if (mcnt_q != MOD_LAST) begin
          acc_d = acc_q + (ACC_W'(prod) << MLO_W);
        end else begin
          if (!mres_q) begin
            h_d = mod_out; cur_d = mod_out;
            if (kind_q == KIND_SEARCH) begin
              walk_d = WK_SEARCH; state_d = ST_WALK_RD;
            end else begin
              state_d = ST_HOME_RD;
            end
          end else begin
            rh_d = mod_out;
            repl_d = mod_out != h_q;
            cur_d = (mod_out != h_q) ? mod_out : h_q;
            walk_d = (mod_out != h_q) ? WK_PRED : WK_TAIL;
            state_d = ST_WALK_RD;
          end
        end
      end
      ST_HOME_RD: state_d = ST_HOME_CHK;
      ST_HOME_CHK: begin
        if (!rd_occ_q) begin
          we_rec = 1'b1; we_link = 1'b1; wr_addr = h_q;
          occ_d[h_q] = 1'b1;
          res_stat_d = STAT_INSERTED; res_slot_d = h_q; res_pay_d = '0;
          state_d = ST_DONE;
        end else begin
          rk_d = rd_key_q; rpay_d = rd_pay_q; rlink_d = rd_link_q;
          fs_d = h_q; fn_d = '0;
          state_d = ST_FREE;
        end
      end
      ST_FREE: begin
        if (!occ_q[fs_q]) begin
          f_d = fs_q; src_d = rk_q; mcnt_d = '0; mres_d = 1'b1;
          state_d = ST_MOD;
        end else if (fn_q == LAST) begin
          res_stat_d = STAT_FULL; res_slot_d = '0; res_pay_d = '0;
          state_d = ST_DONE;
        end else begin
          fs_d = (fs_q == LAST) ? '0 : fs_q + 1'b1;
          fn_d = fn_q + 1'b1;
        end
      end
      ST_WALK_RD: begin
        n_d = '0;
        state_d = ST_WALK;
      end
      ST_WALK: begin
        n_d = n_q + 1'b1;
        cur_d = IW'(lk);
        case (walk_q)
          WK_SEARCH: begin
            if (!n_end && key_hit) begin
              res_stat_d = STAT_FOUND; res_slot_d = cur_q; res_pay_d = rd_pay_q;
              state_d = ST_DONE;
            end else if (n_end || lk_end) begin
              res_stat_d = STAT_MISSING; res_slot_d = '0; res_pay_d = '0;
              state_d = ST_DONE;
            end
          end
          WK_TAIL: begin
            if (n_end || lk_end) begin
              t_d = cur_q; state_d = ST_WR_T;
            end
          end
          default: begin
            if (!n_end && lk == LW'(h_q)) begin
              p_d = cur_q; state_d = ST_WR_P;
            end else if (n_end || lk_end) begin
              cur_d = rh_q; walk_d = WK_TAIL; state_d = ST_WALK_RD;
            end
          end
        endcase
      end
      ST_WR_P: begin
        we_link = 1'b1; wr_addr = p_q; wr_link = rlink_q;
        cur_d = p_q; walk_d = WK_TAIL; state_d = ST_WALK_RD;
      end
      ST_WR_T: begin
        we_link = 1'b1; wr_addr = t_q; wr_link = LW'(f_q);
        state_d = ST_WR_F;
      end
      ST_WR_F: begin
        we_rec = 1'b1; we_link = 1'b1; wr_addr = f_q;
        wr_key = repl_q ? rk_q : key_q;
        wr_pay = repl_q ? rpay_q : pay_q;
        occ_d[f_q] = 1'b1;
        res_stat_d = STAT_INSERTED; res_slot_d = f_q; res_pay_d = '0;
        state_d = repl_q ? ST_WR_H : ST_DONE;
      end
      ST_WR_H: begin
        we_rec = 1'b1; we_link = 1'b1; wr_addr = h_q;
        res_slot_d = h_q;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        out_o.valid = 1'b1;
        if (out_o.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_o.status        = res_stat_q;
  assign out_o.slot          = SLOT_W'(res_slot_q);
  assign out_o.found_payload = res_pay_q;

  `HTC_ASSERT_NOW(a_ready_not_busy, in_i.ready, !out_o.valid, "ready while result pending")
  `HTC_ASSERT_NEXT(a_accept_blocks, in_i.valid && in_i.ready, !in_i.ready, "beat taken twice")
  `HTC_ASSERT_NOW(a_free_slot_empty, state_q == ST_WR_F, !occ_q[f_q], "free slot overwritten")
endmodule
`default_nettype wire
